// ===== hdl/bus_mouse_interface_macros.svh =====
// assertion macros for the bus mouse interface block
// users need signals named clock and reset in scope
`ifndef BUS_MOUSE_INTERFACE_MACROS_SVH
`define BUS_MOUSE_INTERFACE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BMI_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bus mouse interface assertion failed");

// next-cycle implication
`define BMI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bus mouse interface assertion failed");

// holds on every edge
`define BMI_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bus mouse interface assertion failed");

`else

`define BMI_ASSERT_SAME(label, ante, cons)
`define BMI_ASSERT_NEXT(label, ante, cons)
`define BMI_ASSERT_ALWAYS(label, cond)

`endif

`endif

// ===== hdl/bmi_pkg.sv =====
// types and codes shared by the bus mouse interface block
// no dependencies
`default_nettype none

package bmi_pkg;

   localparam logic [1:0] ACT_EVENT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   localparam logic [3:0] PORT_DATA   = 4'hC;
   localparam logic [3:0] PORT_SIG    = 4'hD;
   localparam logic [3:0] PORT_CTRL   = 4'hE;

   localparam logic [7:0] CMD_X_LO = 8'h80;
   localparam logic [7:0] CMD_X_HI = 8'hA0;
   localparam logic [7:0] CMD_Y_LO = 8'hC0;
   localparam logic [7:0] CMD_Y_HI = 8'hE0;

   localparam logic [7:0] SIG_VALUE  = 8'hA5;
   localparam logic [7:0] ROT_RESET  = 8'h01;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         port_addr;
      logic [7:0]         write_value;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic signed [15:0] delta_wheel;
      logic [2:0]         button_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/bmi_core.sv =====
// mouse state registers and the per-transfer update logic
// depends on bmi_pkg and bus_mouse_interface_macros.svh
`default_nettype none
`include "bus_mouse_interface_macros.svh"

module bmi_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire bmi_pkg::req_type item,
   output bmi_pkg::rsp_type     result,
   output logic                 irq_state
);

   logic [7:0]  command_ff,   command_in;
   logic [15:0] acc_x_ff,     acc_x_in;
   logic [15:0] acc_y_ff,     acc_y_in;
   logic [15:0] acc_wheel_ff, acc_wheel_in;
   logic [2:0]  buttons_ff,   buttons_in;
   logic        pending_ff,   pending_in;
   logic [7:0]  rot_ff,       rot_in;

   logic [15:0] sum_x, sum_y, sum_wheel;
   logic        null_event;
   logic [7:0]  read_data;

   // raw bit patterns wrap modulo 2^16
   assign sum_x     = acc_x_ff + 16'(unsigned'(item.delta_x));
   assign sum_y     = acc_y_ff + 16'(unsigned'(item.delta_y));
   assign sum_wheel = acc_wheel_ff + 16'(unsigned'(item.delta_wheel));
   assign null_event = (sum_x == '0) && (sum_y == '0) && (sum_wheel == '0)
                       && (buttons_ff == item.button_bits);

   always_comb begin
      command_in   = command_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_wheel_in = acc_wheel_ff;
      buttons_in   = buttons_ff;
      pending_in   = pending_ff;
      rot_in       = rot_ff;
      read_data    = '0;
      case (item.action)
         bmi_pkg::ACT_EVENT: begin
            acc_x_in     = sum_x;
            acc_y_in     = sum_y;
            acc_wheel_in = sum_wheel;
            if (!null_event) begin
               buttons_in = item.button_bits;
               pending_in = 1'b1;
            end
         end
         bmi_pkg::ACT_READ: begin
            case (item.port_addr)
               bmi_pkg::PORT_DATA: begin
                  pending_in = 1'b0;
                  case (command_ff)
                     bmi_pkg::CMD_X_LO: read_data = {~buttons_ff, 1'b0, acc_x_ff[3:0]};
                     bmi_pkg::CMD_X_HI: begin
                        read_data = {4'h0, acc_x_ff[7:4]};
                        acc_x_in  = '0;
                     end
                     bmi_pkg::CMD_Y_LO: read_data = {4'h0, acc_y_ff[3:0]};
                     bmi_pkg::CMD_Y_HI: begin
                        read_data = {4'h0, acc_y_ff[7:4]};
                        acc_y_in  = '0;
                     end
                     default: read_data = '0;
                  endcase
               end
               bmi_pkg::PORT_SIG: read_data = bmi_pkg::SIG_VALUE;
               bmi_pkg::PORT_CTRL: begin
                  read_data = rot_ff;
                  // state stays one-hot, so a rotate covers the wrap to bit 0
                  rot_in    = {rot_ff[6:0], rot_ff[7]};
               end
               default: read_data = '0;
            endcase
         end
         bmi_pkg::ACT_WRITE: begin
            if (item.port_addr == bmi_pkg::PORT_CTRL) begin
               command_in = item.write_value;
            end
         end
         default: read_data = '0;
      endcase
   end

   assign result.read_data = read_data;
   assign result.irq_line  = pending_in;
   assign irq_state        = pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_wheel_ff <= '0;
         buttons_ff   <= '0;
         pending_ff   <= 1'b0;
         rot_ff       <= bmi_pkg::ROT_RESET;
      end else if (step) begin
         command_ff   <= command_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_wheel_ff <= acc_wheel_in;
         buttons_ff   <= buttons_in;
         pending_ff   <= pending_in;
         rot_ff       <= rot_in;
      end
   end

   `BMI_ASSERT_ALWAYS(a_rot_onehot, $onehot(rot_ff))
   `BMI_ASSERT_NEXT(a_data_read_clears_irq,
      step && item.action == bmi_pkg::ACT_READ && item.port_addr == bmi_pkg::PORT_DATA,
      !pending_ff)
   `BMI_ASSERT_NEXT(a_idle_holds_state, !step,
      $stable(acc_x_ff) && $stable(acc_y_ff) && $stable(pending_ff) && $stable(rot_ff))

endmodule

`default_nettype wire

// ===== hdl/bus_mouse_interface.sv =====
// a transfer accepted into the input register moves on into the result register when it advances
// throughput: one transfer per cycle; a stalled result holds the input register full,
// which stalls req until the result drains
// every item yields exactly one result, computed in a single pass of bmi_core logic
// reset: synchronous, active high; clears the valid flags of both pipeline registers and
// the mouse state, the rotating status returns to 0x01; no clearing pass
`default_nettype none
`include "bus_mouse_interface_macros.svh"

module bus_mouse_interface (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire bmi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output bmi_pkg::rsp_type rsp_data
);

   logic             in_valid_ff;
   bmi_pkg::req_type in_item_ff;
   logic             out_valid_ff;
   bmi_pkg::rsp_type out_data_ff;

   logic             advance;
   bmi_pkg::rsp_type core_result;
   logic             core_irq;

   // item moves into the result register when it is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   bmi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .result    (core_result),
      .irq_state (core_irq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `BMI_ASSERT_NEXT(a_irq_tracks_state, advance, out_data_ff.irq_line == core_irq)
   `BMI_ASSERT_NEXT(a_nonread_zero, advance && in_item_ff.action != bmi_pkg::ACT_READ,
      out_data_ff.read_data == 8'h00)
   `BMI_ASSERT_NEXT(a_held_item_kept, in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff))
   `BMI_ASSERT_SAME(a_advance_needs_room, advance, !out_valid_ff || !rsp_stall)

endmodule

`default_nettype wire

// ===== bench/bus_mouse_interface_tb.sv =====
// self-checking bench for the bus mouse interface block: mouse events and port accesses
// in, read bytes and irq level out, checked against a scoreboard that models the state
// depends on bmi_pkg and the bus_mouse_interface rtl
`default_nettype none

module bus_mouse_interface_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam logic [3:0] PORT_LOW    = 4'h0;
   localparam logic [3:0] PORT_TOP    = 4'hF;
   localparam logic [7:0] CMD_NONE    = 8'h00;
   localparam logic [7:0] CMD_ALL     = 8'hFF;
   localparam int         RANDOM_ITEMS = 1250;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         MAX_REPORTS  = 10;
   localparam int         CYCLE_LIMIT  = 200000;

   class mouse_port_scoreboard;
      logic [7:0]       command;
      logic [15:0]      acc_x;
      logic [15:0]      acc_y;
      logic [15:0]      acc_wheel;
      logic [2:0]       buttons;
      logic             irq;
      logic [7:0]       rotating;
      bmi_pkg::rsp_type expected_q[$];
      int               errors;

      function new();
         command   = CMD_NONE;
         acc_x     = '0;
         acc_y     = '0;
         acc_wheel = '0;
         buttons   = '0;
         irq       = 1'b0;
         rotating  = bmi_pkg::ROT_RESET;
         errors    = 0;
      endfunction

      // work out the result of one accepted transfer and queue it
      function void note_transfer(bmi_pkg::req_type item);
         bmi_pkg::rsp_type res;
         logic [7:0]       shifted;
         res = '0;
         case (item.action)
            bmi_pkg::ACT_EVENT: begin
               acc_x     = acc_x + item.delta_x;
               acc_y     = acc_y + item.delta_y;
               acc_wheel = acc_wheel + item.delta_wheel;
               // null event: nothing moved net and buttons unchanged
               if (!(acc_x == '0 && acc_y == '0 && acc_wheel == '0 &&
                     buttons == item.button_bits)) begin
                  buttons = item.button_bits;
                  irq     = 1'b1;
               end
            end
            bmi_pkg::ACT_READ: begin
               case (item.port_addr)
                  bmi_pkg::PORT_DATA: begin
                     irq = 1'b0;
                     case (command)
                        bmi_pkg::CMD_X_LO: res.read_data = {~buttons, 1'b0, acc_x[3:0]};
                        bmi_pkg::CMD_X_HI: begin
                           res.read_data = {4'h0, acc_x[7:4]};
                           acc_x = '0;
                        end
                        bmi_pkg::CMD_Y_LO: res.read_data = {4'h0, acc_y[3:0]};
                        bmi_pkg::CMD_Y_HI: begin
                           res.read_data = {4'h0, acc_y[7:4]};
                           acc_y = '0;
                        end
                        default: res.read_data = '0;
                     endcase
                  end
                  bmi_pkg::PORT_SIG: res.read_data = bmi_pkg::SIG_VALUE;
                  bmi_pkg::PORT_CTRL: begin
                     res.read_data = rotating;
                     shifted = rotating << 1;
                     rotating = (shifted == '0) ? bmi_pkg::ROT_RESET : shifted;
                  end
                  default: res.read_data = '0;
               endcase
            end
            bmi_pkg::ACT_WRITE: begin
               if (item.port_addr == bmi_pkg::PORT_CTRL) command = item.write_value;
            end
            default: ;
         endcase
         res.irq_line = irq;
         expected_q.push_back(res);
      endfunction

      function void flag(string what, logic [7:0] want_v, logic [7:0] got_v);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want_v, got_v);
      endfunction

      function void check_result(bmi_pkg::rsp_type got);
         bmi_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            flag("result with nothing expected", 8'h00, got.read_data);
            return;
         end
         want = expected_q.pop_front();
         if (got.read_data !== want.read_data) flag("read_data", want.read_data, got.read_data);
         if (got.irq_line !== want.irq_line) flag("irq_line", want.irq_line, got.irq_line);
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bmi_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bmi_pkg::rsp_type rsp_data;

   mouse_port_scoreboard sb = new();

   int sender_idle_pct    = 7;
   int receiver_stall_pct = 60;
   int hold_gen_req       = 0;
   int hold_gen_seen      = 0;
   int hold_left          = 0;
   int cycles             = 0;

   bus_mouse_interface u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // both channels are sampled at the same edge; latency keeps them apart
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_transfer(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // receiver: random stalls, plus a long hold-off when the stimulus asks for one
   always @(negedge clock) begin
      if (hold_gen_seen != hold_gen_req) begin
         hold_gen_seen = hold_gen_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input bmi_pkg::req_type item);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic bmi_pkg::req_type make_access(logic [1:0] act, logic [3:0] port,
                                                    logic [7:0] value, logic [15:0] dx,
                                                    logic [15:0] dy, logic [15:0] dw,
                                                    logic [2:0] btn);
      bmi_pkg::req_type item;
      item.action      = act;
      item.port_addr   = port;
      item.write_value = value;
      item.delta_x     = dx;
      item.delta_y     = dy;
      item.delta_wheel = dw;
      item.button_bits = btn;
      return item;
   endfunction

   function automatic logic [15:0] extreme_delta();
      case ($urandom_range(0, 3))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 4))
         0:       return bmi_pkg::CMD_X_LO;
         1:       return bmi_pkg::CMD_X_HI;
         2:       return bmi_pkg::CMD_Y_LO;
         3:       return bmi_pkg::CMD_Y_HI;
         default: return 8'($urandom());
      endcase
   endfunction

   // mostly command writes, data port reads and motion; the rest is noise
   function automatic bmi_pkg::req_type make_random_access();
      bmi_pkg::req_type item;
      logic [95:0]      raw;
      int               pick;
      raw  = {$urandom(), $urandom(), $urandom()};
      item = raw[$bits(bmi_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         item.action = bmi_pkg::ACT_EVENT;
         if ($urandom_range(0, 1)) item.button_bits = sb.buttons;
         case ($urandom_range(0, 3))
            0: begin
               item.delta_x     = 16'($urandom_range(0, 16) - 8);
               item.delta_y     = 16'($urandom_range(0, 16) - 8);
               item.delta_wheel = 16'($urandom_range(0, 2) - 1);
            end
            1: ;
            2: begin
               // cancel every accumulator: a null event
               item.delta_x     = -sb.acc_x;
               item.delta_y     = -sb.acc_y;
               item.delta_wheel = -sb.acc_wheel;
               item.button_bits = sb.buttons;
            end
            default: begin
               item.delta_x     = extreme_delta();
               item.delta_y     = extreme_delta();
               item.delta_wheel = extreme_delta();
            end
         endcase
      end else if (pick < 55) begin
         item.action      = bmi_pkg::ACT_WRITE;
         item.port_addr   = bmi_pkg::PORT_CTRL;
         item.write_value = pick_command();
      end else if (pick < 88) begin
         item.action = bmi_pkg::ACT_READ;
         case ($urandom_range(0, 8))
            6:       item.port_addr = bmi_pkg::PORT_SIG;
            7:       item.port_addr = bmi_pkg::PORT_CTRL;
            8:       ;
            default: item.port_addr = bmi_pkg::PORT_DATA;
         endcase
      end else if (pick < 95) begin
         item.action = bmi_pkg::ACT_WRITE;
      end
      return item;
   endfunction

   task automatic run_directed();
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_SIG, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_CTRL, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      // zero motion, same buttons: dropped
      send_item(make_access(bmi_pkg::ACT_EVENT, PORT_LOW, 8'h00, 16'h0, 16'h0, 16'h0,
                            3'd0));
      send_item(make_access(bmi_pkg::ACT_EVENT, PORT_TOP, CMD_ALL, 16'h7FFF, 16'h8000,
                            16'hFFFF, 3'd7));
      // writes away from the control port are ignored
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_DATA, CMD_ALL, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_CTRL, bmi_pkg::CMD_X_LO,
                            16'h0, 16'h0, 16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_CTRL, bmi_pkg::CMD_X_HI,
                            16'h0, 16'h0, 16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_CTRL, bmi_pkg::CMD_Y_LO,
                            16'h0, 16'h0, 16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_CTRL, bmi_pkg::CMD_Y_HI,
                            16'h0, 16'h0, 16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(ACT_UNUSED, bmi_pkg::PORT_CTRL, CMD_ALL, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 3'd7));
      // every accumulator cancelled with the buttons unchanged: dropped
      send_item(make_access(bmi_pkg::ACT_EVENT, PORT_LOW, 8'h00, -sb.acc_x, -sb.acc_y,
                            -sb.acc_wheel, sb.buttons));
      send_item(make_access(bmi_pkg::ACT_READ, PORT_TOP, 8'h00, 16'h0, 16'h0, 16'h0,
                            3'd0));
      send_item(make_access(bmi_pkg::ACT_WRITE, bmi_pkg::PORT_CTRL, CMD_ALL, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_DATA, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
      send_item(make_access(bmi_pkg::ACT_EVENT, PORT_LOW, 8'h00, 16'h0, 16'h0, 16'h0,
                            3'd2));
      send_item(make_access(bmi_pkg::ACT_READ, PORT_LOW, 8'h00, 16'h0, 16'h0, 16'h0,
                            3'd0));
      send_item(make_access(bmi_pkg::ACT_READ, bmi_pkg::PORT_CTRL, 8'h00, 16'h0, 16'h0,
                            16'h0, 3'd0));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      wait_for_drain();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 7;
               receiver_stall_pct = 60;
            end
            1: begin
               sender_idle_pct    = 60;
               receiver_stall_pct = 7;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            // long receiver hold-off while transfers keep coming
            if (n == 100) hold_gen_req++;
            if (n == 250) wait_for_drain();
            send_item(make_random_access());
         end
      end
      wait_for_drain();
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
